// ===== rtl/core/key_edge_and_double_click_qualifier_macros.svh =====
// Assertion macros for the key edge and double-click qualifier.
// Each macro expects clk_i and rst_ni to be in scope where it is used.
`ifndef KEY_EDGE_AND_DOUBLE_CLICK_QUALIFIER_MACROS_SVH
`define KEY_EDGE_AND_DOUBLE_CLICK_QUALIFIER_MACROS_SVH

`define KDC_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

`define KDC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define KDC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/kdcq_pkg.sv =====
// Package for the key edge and double-click qualifier.
// Holds the transfer payload types and the fixed bit positions and codes; no dependencies.
package kdcq_pkg;

  localparam logic OpScan = 1'b0;
  localparam logic OpTick = 1'b1;

  localparam int unsigned KeyCount = 9;
  localparam int unsigned LineCount = 3;
  localparam int unsigned ZeroKeyBit = 8;
  localparam int unsigned LineResetBit = 0;
  localparam int unsigned LineStartBit = 1;
  localparam int unsigned LineStopBit = 2;

  localparam int unsigned WindowWidth = 16;
  localparam logic [WindowWidth-1:0] ClickWindowReset = 16'd1000;

  typedef struct packed {
    logic                 op;
    logic [KeyCount-1:0]  key_pins;
    logic [LineCount-1:0] line_pins;
  } in_item_t;

  typedef struct packed {
    logic [KeyCount-2:0] key_events;
    logic                zero_single;
    logic                zero_double;
    logic                reset_single;
    logic                reset_double;
    logic                start_event;
    logic                stop_event;
  } out_item_t;

endpackage

// ===== rtl/core/key_edge_and_double_click_qualifier.sv =====
// Key edge and double-click qualifier: a top level built as one register stage per side.
// Depends on kdcq_pkg and key_edge_and_double_click_qualifier_macros.svh.
//
// Each transfer in is either a scan of active-low key and line levels or a one-millisecond
// tick, and gives exactly one transfer out. The block takes one item every cycle unless
// in_stall_o holds it; an item is captured in the input register and then moves into the
// result register. The edge detection, window timers and expiry compare sit between those
// two registers. A stalled result holds the input register, so in_stall_o follows
// out_stall_i in the same cycle once both registers are full. The click window register
// may be written at any time the block is idle; cfg_ready_o is always high.
`include "key_edge_and_double_click_qualifier_macros.svh"

module key_edge_and_double_click_qualifier #(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_valid_i,
  output logic                                     in_stall_o,
  input  kdcq_pkg::in_item_t                       in_data_i,
  output logic                                     out_valid_o,
  input  logic                                     out_stall_i,
  output kdcq_pkg::out_item_t                      out_data_o,
  input  logic                                     cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  logic [kdcq_pkg::WindowWidth-1:0]         cfg_data_i
);

  localparam int unsigned CmpWidth =
      (TIMER_WIDTH > kdcq_pkg::WindowWidth) ? TIMER_WIDTH : kdcq_pkg::WindowWidth;

  logic [kdcq_pkg::WindowWidth-1:0] window_q;

  logic                 s1_valid_q;
  kdcq_pkg::in_item_t   s1_item_q;
  logic                 out_valid_q;
  kdcq_pkg::out_item_t  out_item_q;
  kdcq_pkg::out_item_t  res_d;

  logic [kdcq_pkg::KeyCount-1:0]  key_prev_q, key_prev_d;
  logic [kdcq_pkg::LineCount-1:0] line_prev_q, line_prev_d;
  logic                           zero_pending_q, zero_pending_d;
  logic                           reset_pending_q, reset_pending_d;
  logic [TIMER_WIDTH-1:0]         zero_timer_q, zero_timer_d;
  logic [TIMER_WIDTH-1:0]         reset_timer_q, reset_timer_d;

  logic                           out_free;
  logic                           advance;
  logic                           in_accept;
  logic [kdcq_pkg::KeyCount-1:0]  key_now;
  logic [kdcq_pkg::KeyCount-1:0]  key_edge;
  logic [kdcq_pkg::LineCount-1:0] line_now;
  logic [kdcq_pkg::LineCount-1:0] line_edge;
  logic [TIMER_WIDTH-1:0]         zero_timer_inc;
  logic [TIMER_WIDTH-1:0]         reset_timer_inc;
  logic                           zero_expired;
  logic                           reset_expired;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign advance     = s1_valid_q && out_free;
  assign in_stall_o  = s1_valid_q && !out_free;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_item_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= kdcq_pkg::ClickWindowReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      window_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_item_q <= in_data_i;
    end
  end

  always_comb begin
    key_now   = ~s1_item_q.key_pins;
    line_now  = ~s1_item_q.line_pins;
    key_edge  = key_now & ~key_prev_q;
    line_edge = line_now & ~line_prev_q;

    zero_timer_inc  = (&zero_timer_q) ? zero_timer_q : zero_timer_q + 1'b1;
    reset_timer_inc = (&reset_timer_q) ? reset_timer_q : reset_timer_q + 1'b1;
    zero_expired  = CmpWidth'(zero_timer_inc) >= CmpWidth'(window_q);
    reset_expired = CmpWidth'(reset_timer_inc) >= CmpWidth'(window_q);

    res_d           = '0;
    key_prev_d      = key_prev_q;
    line_prev_d     = line_prev_q;
    zero_pending_d  = zero_pending_q;
    reset_pending_d = reset_pending_q;
    zero_timer_d    = zero_timer_q;
    reset_timer_d   = reset_timer_q;

    if (s1_item_q.op == kdcq_pkg::OpTick) begin
      zero_timer_d  = zero_timer_inc;
      reset_timer_d = reset_timer_inc;
      if (zero_pending_q && zero_expired) begin
        zero_pending_d    = 1'b0;
        res_d.zero_single = 1'b1;
      end
      if (reset_pending_q && reset_expired) begin
        reset_pending_d    = 1'b0;
        res_d.reset_single = 1'b1;
      end
    end else begin
      key_prev_d        = key_now;
      line_prev_d       = line_now;
      res_d.key_events  = key_edge[kdcq_pkg::KeyCount-2:0];
      res_d.start_event = line_edge[kdcq_pkg::LineStartBit];
      res_d.stop_event  = line_edge[kdcq_pkg::LineStopBit];
      if (key_edge[kdcq_pkg::ZeroKeyBit]) begin
        if (zero_pending_q) begin
          zero_pending_d    = 1'b0;
          res_d.zero_double = 1'b1;
        end else begin
          zero_pending_d = 1'b1;
          zero_timer_d   = '0;
        end
      end
      if (line_edge[kdcq_pkg::LineResetBit]) begin
        if (reset_pending_q) begin
          reset_pending_d    = 1'b0;
          res_d.reset_double = 1'b1;
        end else begin
          reset_pending_d = 1'b1;
          reset_timer_d   = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_prev_q      <= '1;
      line_prev_q     <= '0;
      zero_pending_q  <= 1'b0;
      reset_pending_q <= 1'b0;
      zero_timer_q    <= '0;
      reset_timer_q   <= '0;
    end else if (advance) begin
      key_prev_q      <= key_prev_d;
      line_prev_q     <= line_prev_d;
      zero_pending_q  <= zero_pending_d;
      reset_pending_q <= reset_pending_d;
      zero_timer_q    <= zero_timer_d;
      reset_timer_q   <= reset_timer_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_item_q <= res_d;
    end
  end

  `KDC_ASSERT_IMPL(a_tick_result_clean,
      out_valid_q && (out_item_q.zero_single || out_item_q.reset_single),
      out_item_q.key_events == '0 && !out_item_q.start_event && !out_item_q.stop_event,
      "A single click result carries scan events.")
  `KDC_ASSERT_NEXT(a_zero_double_closes, advance && res_d.zero_double, !zero_pending_q,
      "Zero key window still open after a double click.")
  `KDC_ASSERT_NEXT(a_reset_single_closes, advance && res_d.reset_single, !reset_pending_q,
      "Reset line window still open after a single click.")
  `KDC_ASSERT_ALWAYS(a_stall_needs_item, !in_stall_o || (s1_valid_q && out_valid_q),
      "Input stalled while the pipeline has room.")

endmodule
